// ===== rtl/grpe_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// grpe_pkg: shared types, constants and helpers of the glyph row expander
// Palettes, the line-drawing glyph table, register indexes and the record
// that travels from the front end to the back end.
// ============================================================================
package grpe_pkg;

    // Default sizes of the glyph store
    localparam int GLYPH_COUNT_DEF = 256;
    localparam int GLYPH_LINES_DEF = 16;
    localparam int MAX_GLYPH_WIDTH = 8;

    // Depth of the queue between front and back end
    localparam int QUEUE_DEPTH = 4;

    // Widths of the partial offset terms
    localparam int ROW_LINE_W = 17;   // cell_row * glyph_height + glyph_line
    localparam int COL_W_W    = 15;   // cell_col * width
    localparam int PROD_B_W   = 18;   // cell_col * width * bytes_per_pixel

    // Item kinds
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

    // Register indexes
    localparam logic [2:0] CFG_SUPPRESS = 3'd0;
    localparam logic [2:0] CFG_PITCH    = 3'd1;
    localparam logic [2:0] CFG_BPP      = 3'd2;
    localparam logic [2:0] CFG_WIDTH    = 3'd3;
    localparam logic [2:0] CFG_HEIGHT   = 3'd4;

    // Register reset values
    localparam logic [15:0] PITCH_RST  = 16'd4096;
    localparam logic [2:0]  BPP_RST    = 3'd4;
    localparam logic [3:0]  WIDTH_RST  = 4'd8;
    localparam logic [4:0]  HEIGHT_RST = 5'd16;

    typedef logic [23:0] t_rgb;

    localparam logic [3:0] PAL_DEFAULT = 4'd8;

    localparam t_rgb FG_PALETTE [9] = '{
        24'h1e1e1e, 24'hff453a, 24'h32d74b, 24'hffd60a,
        24'h0a84ff, 24'hbf5af2, 24'h5ac8fa, 24'hdedede, 24'hffffff
    };
    localparam t_rgb BG_PALETTE [9] = '{
        24'h1e1e1e, 24'hff453a, 24'h32d74b, 24'hffd60a,
        24'h0a84ff, 24'hbf5af2, 24'h5ac8fa, 24'hffffff, 24'h1e1e1e
    };

    // Line-drawing glyphs: bit g set when glyph g has a stroke above / below
    // the middle line
    localparam logic [10:0] BOX_UPPER    = 11'b101_1101_1001;
    localparam logic [10:0] BOX_LOWER    = 11'b110_1101_0110;
    localparam logic [7:0]  BOX_STROKE   = 8'h08;
    localparam logic [3:0]  BOX_MID_LINE = 4'd7;
    localparam logic [7:0]  BOX_MIDDLE [11] = '{
        8'hf0, 8'hf0, 8'h07, 8'h07, 8'hff, 8'hff,
        8'h0f, 8'hf8, 8'hff, 8'hff, 8'h08
    };

    typedef struct packed {
        logic       hit;
        logic [7:0] bits;
    } t_box_line;

    typedef struct packed {
        logic       suppressed;
        logic [3:0] width;
        logic [4:0] height;
    } t_front_cfg;

    typedef struct packed {
        logic [15:0] pitch;
        logic [2:0]  bpp;
    } t_back_cfg;

    // One draw item, classified and ready for the back end
    typedef struct packed {
        logic [7:0]            bits;
        t_rgb                  fg;
        t_rgb                  bg;
        logic [3:0]            width;
        logic [ROW_LINE_W-1:0] row_line;
        logic [COL_W_W-1:0]    col_w;
    } t_draw;

    function automatic t_rgb pick_fg(input logic [3:0] idx);
        return FG_PALETTE[(idx > PAL_DEFAULT) ? PAL_DEFAULT : idx];
    endfunction

    function automatic t_rgb pick_bg(input logic [3:0] idx);
        return BG_PALETTE[(idx > PAL_DEFAULT) ? PAL_DEFAULT : idx];
    endfunction

    function automatic t_box_line box_line(input logic [7:0] code,
                                           input logic [3:0] line);
        t_box_line  res;
        logic [7:0] g8;
        logic [3:0] g;
        res.hit = 1'b1;
        g8      = 8'h00;
        if (code inside {[8'h6a:8'h6e]}) begin
            g8 = code - 8'h6a;
        end else if (code == 8'h71) begin
            g8 = 8'd5;
        end else if (code inside {[8'h74:8'h78]}) begin
            g8 = code - 8'h74 + 8'd6;
        end else begin
            res.hit = 1'b0;
        end
        g = g8[3:0];
        if (line < BOX_MID_LINE) begin
            res.bits = BOX_UPPER[g] ? BOX_STROKE : 8'h00;
        end else if (line == BOX_MID_LINE) begin
            res.bits = BOX_MIDDLE[g];
        end else begin
            res.bits = BOX_LOWER[g] ? BOX_STROKE : 8'h00;
        end
        return res;
    endfunction

endpackage

// ===== rtl/grpe_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// grpe_front: item intake and classification
// Writes load items into the glyph store, drops draw items that give no
// pixels, reads the glyph line and starts the offset arithmetic.
// ============================================================================
module grpe_front
    import grpe_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int GLYPH_LINES = GLYPH_LINES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_front_cfg  i_cfg,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_char_code,
    input  logic        i_box_drawing,
    input  logic [3:0]  i_glyph_line,
    input  logic [7:0]  i_line_bits,
    input  logic [11:0] i_cell_col,
    input  logic [11:0] i_cell_row,
    input  logic [3:0]  i_fg_index,
    input  logic [3:0]  i_bg_index,
    input  logic        i_q_full,
    output logic        o_push,
    output t_draw       o_draw
);

    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_LINES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    logic                  accept;
    logic                  is_draw;
    logic                  store_hit;
    logic                  draw_ok;
    t_box_line             box;
    logic [3:0]            width;
    logic [ADDR_W-1:0]     addr;
    logic [ROW_LINE_W-1:0] row_line;
    logic [COL_W_W-1:0]    col_w;

    logic                  r_valid;
    logic                  r_is_box;
    logic [7:0]            r_box_bits;
    logic [7:0]            r_rdata;
    t_rgb                  r_fg;
    t_rgb                  r_bg;
    logic [3:0]            r_width;
    logic [ROW_LINE_W-1:0] r_row_line;
    logic [COL_W_W-1:0]    r_col_w;

    logic [7:0]            r_store [STORE_DEPTH];

    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;

    assign is_draw   = (i_action == ACT_DRAW);
    assign store_hit = (int'(i_char_code) < GLYPH_COUNT) && (int'(i_glyph_line) < GLYPH_LINES);
    assign box       = box_line(i_char_code, i_glyph_line);
    assign width     = (i_cfg.width > 4'(MAX_GLYPH_WIDTH)) ? 4'(MAX_GLYPH_WIDTH) : i_cfg.width;

    assign draw_ok = is_draw && !i_cfg.suppressed
                   && ({1'b0, i_glyph_line} < i_cfg.height)
                   && (i_cfg.width != 4'd0)
                   && (i_box_drawing ? box.hit : store_hit);

    assign addr     = ADDR_W'(int'(i_char_code) * GLYPH_LINES + int'(i_glyph_line));
    assign row_line = ROW_LINE_W'(i_cell_row) * ROW_LINE_W'(i_cfg.height)
                    + ROW_LINE_W'(i_glyph_line);
    assign col_w    = COL_W_W'(i_cell_col) * COL_W_W'(width);

    // Glyph store: one access per accepted item, write for loads, read for draws
    always_ff @(posedge i_clk) begin
        if (accept && !is_draw && store_hit) begin
            r_store[addr] <= i_line_bits;
        end
        if (accept && is_draw && store_hit) begin
            r_rdata <= r_store[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= draw_ok;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_box   <= i_box_drawing;
            r_box_bits <= box.bits;
            r_fg       <= pick_fg(i_fg_index);
            r_bg       <= pick_bg(i_bg_index);
            r_width    <= width;
            r_row_line <= row_line;
            r_col_w    <= col_w;
        end
    end

    assign o_draw.bits     = r_is_box ? r_box_bits : r_rdata;
    assign o_draw.fg       = r_fg;
    assign o_draw.bg       = r_bg;
    assign o_draw.width    = r_width;
    assign o_draw.row_line = r_row_line;
    assign o_draw.col_w    = r_col_w;

`ifndef ASSERT_OFF
    // A held draw item must not be overwritten by a new accept
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_q_full) |-> !accept)
        else $error("front stage overwritten while queue full");
`endif

endmodule

// ===== rtl/grpe_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// grpe_queue: short queue of draw items
// Decouples the front end from the back end so each side stalls on its own.
// ============================================================================
module grpe_queue
    import grpe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_draw i_draw,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_draw o_draw
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [PTR_W:0]   r_count;
    t_draw            r_entry [QUEUE_DEPTH];

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_draw  = r_entry[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_draw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/grpe_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// grpe_back: offset arithmetic and pixel expansion
// Two registered stages: the pitch and pixel-size products, then the final
// offset sum and palette expansion into the output register.
// ============================================================================
module grpe_back
    import grpe_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_back_cfg                      i_cfg,
    input  logic                           i_q_valid,
    output logic                           o_pop,
    input  t_draw                          i_draw,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [31:0]                    o_byte_offset,
    output logic [3:0]                     o_pixel_count,
    output t_rgb [MAX_GLYPH_WIDTH-1:0]     o_pixel
);

    logic                          advance;
    logic [ROW_LINE_W+15:0]        prod_a;
    t_rgb [MAX_GLYPH_WIDTH-1:0]    pixel;

    logic                          r_b1_valid;
    logic [31:0]                   r_prod_a;
    logic [PROD_B_W-1:0]           r_prod_b;
    logic [7:0]                    r_bits;
    t_rgb                          r_fg;
    t_rgb                          r_bg;
    logic [3:0]                    r_width;

    logic                          r_out_valid;
    logic [31:0]                   r_offset;
    logic [3:0]                    r_count;
    t_rgb [MAX_GLYPH_WIDTH-1:0]    r_pixel;

    // Move the whole back pipe unless the output register is held
    assign advance = !(r_out_valid && i_out_stall);
    assign o_pop   = i_q_valid && advance;

    assign prod_a = (ROW_LINE_W+16)'(i_draw.row_line) * (ROW_LINE_W+16)'(i_cfg.pitch);

    always_comb begin
        for (int j = 0; j < MAX_GLYPH_WIDTH; j++) begin
            if (4'(j) < r_width) begin
                pixel[j] = r_bits[MAX_GLYPH_WIDTH-1-j] ? r_fg : r_bg;
            end else begin
                pixel[j] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_b1_valid  <= o_pop;
            r_out_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_prod_a <= prod_a[31:0];
            r_prod_b <= PROD_B_W'(i_draw.col_w) * PROD_B_W'(i_cfg.bpp);
            r_bits   <= i_draw.bits;
            r_fg     <= i_draw.fg;
            r_bg     <= i_draw.bg;
            r_width  <= i_draw.width;
            r_offset <= r_prod_a + 32'(r_prod_b);
            r_count  <= r_width;
            r_pixel  <= pixel;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_byte_offset = r_offset;
    assign o_pixel_count = r_count;
    assign o_pixel       = r_pixel;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pixel_count != 4'd0 && o_pixel_count <= 4'(MAX_GLYPH_WIDTH)))
        else $error("pixel count out of range");
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pixel_count != 4'(MAX_GLYPH_WIDTH))
            |-> (o_pixel[MAX_GLYPH_WIDTH-1] == '0))
        else $error("unused pixel not cleared");
`endif

endmodule

// ===== rtl/glyph_row_pixel_expander.sv =====
`timescale 1ns / 1ps
// ============================================================================
// glyph_row_pixel_expander: bitmap font character generator
// Loads glyph lines into a glyph store and expands drawn glyph lines into
// a framebuffer byte offset and up to eight palette colored pixels.
// ============================================================================
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------
//  in      | i_in_valid / o_in_stall    | action, char_code, box_drawing,
//          |                            | glyph_line, line_bits, cell_col,
//          |                            | cell_row, fg_index, bg_index
//  out     | o_out_valid / i_out_stall  | byte_offset, pixel_count,
//          |                            | pixel_0 .. pixel_7
//  cfg     | i_cfg_valid / o_cfg_ready  | cfg_index, cfg_data
//
//  One item per clock sustained while the input is not stalled; the glyph store has one port and
//  serves one load write or one draw read per cycle, which sets that rate.
//  A draw result passes the front register, a queue entry, the product stage and the output
//  register before it is valid at the output; output stalls can hold it on the way.
//  Reset is synchronous and leaves the glyph store as it is; never-loaded lines read undefined.
//  An output stall holds the back pipe; the input stalls only once the queue is full.
//
module glyph_row_pixel_expander
    import grpe_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int GLYPH_LINES = GLYPH_LINES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_char_code,
    input  logic        i_box_drawing,
    input  logic [3:0]  i_glyph_line,
    input  logic [7:0]  i_line_bits,
    input  logic [11:0] i_cell_col,
    input  logic [11:0] i_cell_row,
    input  logic [3:0]  i_fg_index,
    input  logic [3:0]  i_bg_index,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_byte_offset,
    output logic [3:0]  o_pixel_count,
    output logic [23:0] o_pixel_0,
    output logic [23:0] o_pixel_1,
    output logic [23:0] o_pixel_2,
    output logic [23:0] o_pixel_3,
    output logic [23:0] o_pixel_4,
    output logic [23:0] o_pixel_5,
    output logic [23:0] o_pixel_6,
    output logic [23:0] o_pixel_7,
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers
    logic        r_suppressed;
    logic [15:0] r_pitch;
    logic [2:0]  r_bpp;
    logic [3:0]  r_width;
    logic [4:0]  r_height;

    t_front_cfg                 front_cfg;
    t_back_cfg                  back_cfg;
    logic                       push;
    logic                       q_full;
    logic                       q_valid;
    logic                       pop;
    t_draw                      front_draw;
    t_draw                      back_draw;
    t_rgb [MAX_GLYPH_WIDTH-1:0] pixel;

    // Registers are always writable; writes must come only while the block is idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_suppressed <= 1'b0;
            r_pitch      <= PITCH_RST;
            r_bpp        <= BPP_RST;
            r_width      <= WIDTH_RST;
            r_height     <= HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SUPPRESS: r_suppressed <= i_cfg_data[0];
                CFG_PITCH:    r_pitch      <= i_cfg_data;
                CFG_BPP:      r_bpp        <= i_cfg_data[2:0];
                CFG_WIDTH:    r_width      <= i_cfg_data[3:0];
                CFG_HEIGHT:   r_height     <= i_cfg_data[4:0];
                default: ;    // drop writes to unknown indexes
            endcase
        end
    end

    assign front_cfg.suppressed = r_suppressed;
    assign front_cfg.width      = r_width;
    assign front_cfg.height     = r_height;
    assign back_cfg.pitch       = r_pitch;
    assign back_cfg.bpp         = r_bpp;

    // Front end: take items, update the store, classify draws
    grpe_front #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .GLYPH_LINES (GLYPH_LINES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (front_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_char_code   (i_char_code),
        .i_box_drawing (i_box_drawing),
        .i_glyph_line  (i_glyph_line),
        .i_line_bits   (i_line_bits),
        .i_cell_col    (i_cell_col),
        .i_cell_row    (i_cell_row),
        .i_fg_index    (i_fg_index),
        .i_bg_index    (i_bg_index),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_draw        (front_draw)
    );

    // Queue: absorb output stalls without holding the input until the queue is full
    grpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_draw  (front_draw),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_draw  (back_draw)
    );

    // Back end: offset products, pixel expansion, output register
    grpe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (back_cfg),
        .i_q_valid     (q_valid),
        .o_pop         (pop),
        .i_draw        (back_draw),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_byte_offset (o_byte_offset),
        .o_pixel_count (o_pixel_count),
        .o_pixel       (pixel)
    );

    assign o_pixel_0 = pixel[0];
    assign o_pixel_1 = pixel[1];
    assign o_pixel_2 = pixel[2];
    assign o_pixel_3 = pixel[3];
    assign o_pixel_4 = pixel[4];
    assign o_pixel_5 = pixel[5];
    assign o_pixel_6 = pixel[6];
    assign o_pixel_7 = pixel[7];

endmodule
